### design/u8v_pkg.sv
// Shared types for the restricted UTF-8 checker: error codes, second-byte
// rule codes and the per-string tracking state.
// No dependencies.
package u8v_pkg;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_LEAD = 3'd1,
        ERR_OVER2    = 3'd2,
        ERR_BAD_CONT = 3'd3,
        ERR_OVER3    = 3'd4,
        ERR_SURR     = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        RULE_NONE = 2'd0,
        RULE_E0   = 2'd1,
        RULE_ED   = 2'd2
    } t_rule;

    typedef struct packed {
        logic [1:0] pending;
        t_rule      rule;
        t_err       err;
    } t_state;

    localparam t_state STATE_RESET = '{pending: 2'd0, rule: RULE_NONE, err: ERR_NONE};

    localparam logic [7:0] LEAD_MIN_TWO  = 8'hC2;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] CONT_E0_MIN   = 8'hA0;
    localparam logic [7:0] CONT_ED_MAX   = 8'h9F;

endpackage

### design/utf8_validator_three_byte_unit.sv
// Restricted UTF-8 checker top level: input register, decision step, result register.
// A zero byte's verdict is written from the input register into the result register, then shows on o_valid.
// Throughput: one byte per cycle; only a zero byte waits, while the result side is stalled.
// Reset (synchronous, active low) empties both registers and clears the tracking state.
// Depends on u8v_pkg and u8v_step.
module utf8_validator_three_byte_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_text_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_valid_res,
    output logic [2:0]           o_error_kind
);
    import u8v_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_err       n_verdict;
    logic       r_out_valid;
    t_err       r_out_err;
    logic       out_free;
    logic       advance;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (out_free || r_in_byte != 8'd0);
    assign o_ready  = !r_in_valid || advance;

    u8v_step u_step (
        .i_byte    (r_in_byte),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_verdict (n_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && r_in_byte == 8'd0) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_text_byte;
        end
        if (advance && r_in_byte == 8'd0) begin
            r_out_err <= n_verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_valid_res  = (r_out_err == ERR_NONE);
    assign o_error_kind = r_out_err;

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending != 2'd3)
        else $error("pending count out of range");

    a_error_clears_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err != ERR_NONE |-> (r_state.pending == 2'd0 && r_state.rule == RULE_NONE))
        else $error("sequence state left after error");

    a_rule_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending == 2'd0 |-> r_state.rule == RULE_NONE)
        else $error("rule set with no pending bytes");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte != 8'd0 && r_state.err != ERR_NONE) |=> $stable(r_state.err))
        else $error("first error overwritten");

    a_verdict_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte == 8'd0) |=> (r_state == STATE_RESET && r_out_valid))
        else $error("terminator did not reset state or post verdict");

endmodule

### design/u8v_step.sv
// Per-byte decision logic: next tracking state and verdict for one byte.
// Depends on u8v_pkg.
module u8v_step (
    input  logic [7:0]      i_byte,
    input  u8v_pkg::t_state i_state,
    output u8v_pkg::t_state o_state,
    output u8v_pkg::t_err   o_verdict
);
    import u8v_pkg::*;

    t_state n_state;
    t_err   n_verdict;

    always_comb begin
        n_state   = i_state;
        n_verdict = i_state.err;
        if (i_byte == 8'd0) begin
            if (i_state.err == ERR_NONE && i_state.pending != 2'd0) begin
                n_verdict = ERR_BAD_CONT;
            end
            n_state = STATE_RESET;
        end else if (i_state.err != ERR_NONE) begin
            n_state = i_state;
        end else if (i_state.pending != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                n_state = '{pending: 2'd0, rule: RULE_NONE, err: ERR_BAD_CONT};
            end else if (i_state.pending == 2'd2) begin
                n_state.pending = 2'd1;
                if (i_state.rule == RULE_E0 && i_byte < CONT_E0_MIN) begin
                    n_state.rule = RULE_E0;
                end else if (i_state.rule == RULE_ED && i_byte > CONT_ED_MAX) begin
                    n_state.rule = RULE_ED;
                end else begin
                    n_state.rule = RULE_NONE;
                end
            end else begin
                n_state.pending = 2'd0;
                n_state.rule    = RULE_NONE;
                if (i_state.rule == RULE_E0) begin
                    n_state.err = ERR_OVER3;
                end else if (i_state.rule == RULE_ED) begin
                    n_state.err = ERR_SURR;
                end
            end
        end else if (i_byte[7] == 1'b0) begin
            n_state = i_state;
        end else if (i_byte[7:5] == 3'b110) begin
            if (i_byte < LEAD_MIN_TWO) begin
                n_state = '{pending: 2'd0, rule: RULE_NONE, err: ERR_OVER2};
            end else begin
                n_state.pending = 2'd1;
                n_state.rule    = RULE_NONE;
            end
        end else if (i_byte[7:4] == 4'hE) begin
            n_state.pending = 2'd2;
            if (i_byte == LEAD_E0) begin
                n_state.rule = RULE_E0;
            end else if (i_byte == LEAD_ED) begin
                n_state.rule = RULE_ED;
            end else begin
                n_state.rule = RULE_NONE;
            end
        end else begin
            n_state = '{pending: 2'd0, rule: RULE_NONE, err: ERR_BAD_LEAD};
        end
    end

    assign o_state   = n_state;
    assign o_verdict = n_verdict;

endmodule

### bench/tb_top.sv
// Testbench for utf8_validator_three_byte_unit: drives byte strings with random
// gaps and result stalls, predicts each verdict and checks it in a scoreboard.
// Depends on u8v_pkg and the RTL of the unit.
module tb_top;

    import u8v_pkg::*;

    class utf8_verdict_book;

        typedef struct packed {
            logic ok;
            t_err kind;
        } t_verdict;

        logic [1:0] pending;
        t_rule      rule;
        t_err       err;
        t_verdict   verdicts_due [$];
        int         mismatches;

        function new();
            pending    = 2'd0;
            rule       = RULE_NONE;
            err        = ERR_NONE;
            mismatches = 0;
        endfunction

        function void flag(t_err kind);
            err     = kind;
            pending = 2'd0;
            rule    = RULE_NONE;
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction

        function void note_byte(logic [7:0] b);
            t_verdict want;
            if (b == 8'h00) begin
                if (err == ERR_NONE && pending != 2'd0) begin
                    flag(ERR_BAD_CONT);
                end
                want.ok   = (err == ERR_NONE);
                want.kind = err;
                verdicts_due.push_back(want);
                pending = 2'd0;
                rule    = RULE_NONE;
                err     = ERR_NONE;
                return;
            end
            if (err != ERR_NONE) begin
                return;
            end
            if (pending != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    flag(ERR_BAD_CONT);
                end else if (pending == 2'd2) begin
                    if (!((rule == RULE_E0 && b < CONT_E0_MIN) ||
                          (rule == RULE_ED && b > CONT_ED_MAX))) begin
                        rule = RULE_NONE;
                    end
                    pending = 2'd1;
                end else begin
                    pending = 2'd0;
                    if (rule == RULE_E0) begin
                        flag(ERR_OVER3);
                    end else if (rule == RULE_ED) begin
                        flag(ERR_SURR);
                    end
                    rule = RULE_NONE;
                end
            end else if (b[7] == 1'b0) begin
                return;
            end else if (b[7:5] == 3'b110) begin
                if (b < LEAD_MIN_TWO) begin
                    flag(ERR_OVER2);
                end else begin
                    pending = 2'd1;
                    rule    = RULE_NONE;
                end
            end else if (b[7:4] == 4'b1110) begin
                pending = 2'd2;
                if (b == LEAD_E0) begin
                    rule = RULE_E0;
                end else if (b == LEAD_ED) begin
                    rule = RULE_ED;
                end else begin
                    rule = RULE_NONE;
                end
            end else begin
                flag(ERR_BAD_LEAD);
            end
        endfunction

        function void check_verdict(logic ok, logic [2:0] kind);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected verdict: valid_res=%0b error_kind=%0d", ok, kind);
                end
                return;
            end
            want = verdicts_due.pop_front();
            if (ok !== want.ok || kind !== want.kind) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"verdict mismatch: expected valid_res=%0b error_kind=%0d,",
                              " got valid_res=%0b error_kind=%0d"},
                             want.ok, want.kind, ok, kind);
                end
            end
        endfunction

    endclass

    localparam int STALL_LIMIT = 2000;
    localparam int CALM_TAIL   = 150;
    localparam int TARGET_BYTES = 1400;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_text_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_valid_res;
    logic [2:0] o_error_kind;

    utf8_verdict_book book = new();
    logic [7:0]       stream [$];
    bit               calm = 1'b0;
    int               stall_left = 0;
    int               rx_cycle = 0;
    int               idle_cycles = 0;

    utf8_validator_three_byte_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_valid_res  (o_valid_res),
        .o_error_kind (o_error_kind)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63, 0));
    endfunction

    function automatic logic [7:0] non_cont_byte();
        int pick;
        pick = $urandom_range(191, 1);
        return (pick < 128) ? 8'(pick) : 8'(pick + 64);
    endfunction

    task automatic compose_string();
        int         chars;
        int         pick;
        logic [7:0] lead;
        bit         cut;
        chars = $urandom_range(6, 0);
        cut   = 1'b0;
        for (int n = 0; n < chars && !cut; n++) begin
            pick = $urandom_range(99, 0);
            if (pick < 35) begin
                stream.push_back(8'($urandom_range(127, 1)));
            end else if (pick < 55) begin
                stream.push_back(8'($urandom_range(8'hDF, 8'hC2)));
                stream.push_back(cont_byte());
            end else if (pick < 80) begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                stream.push_back(lead);
                if (lead == LEAD_E0) begin
                    stream.push_back(8'($urandom_range(8'hBF, 8'hA0)));
                end else if (lead == LEAD_ED) begin
                    stream.push_back(8'($urandom_range(8'h9F, 8'h80)));
                end else begin
                    stream.push_back(cont_byte());
                end
                stream.push_back(cont_byte());
            end else if (pick < 86) begin
                if ($urandom_range(1, 0) == 1) begin
                    stream.push_back(LEAD_E0);
                    stream.push_back(8'($urandom_range(8'h9F, 8'h80)));
                end else begin
                    stream.push_back(LEAD_ED);
                    stream.push_back(8'($urandom_range(8'hBF, 8'hA0)));
                end
                stream.push_back(($urandom_range(3, 0) == 0) ? non_cont_byte() : cont_byte());
            end else if (pick < 91) begin
                case ($urandom_range(2, 0))
                    0: stream.push_back(8'($urandom_range(8'hC1, 8'hC0)));
                    1: stream.push_back(8'($urandom_range(8'hFF, 8'hF0)));
                    default: stream.push_back(cont_byte());
                endcase
                stream.push_back(8'($urandom_range(255, 1)));
            end else if (pick < 96) begin
                lead = ($urandom_range(1, 0) == 1) ? 8'($urandom_range(8'hDF, 8'hC2))
                                                   : 8'($urandom_range(8'hEF, 8'hE0));
                stream.push_back(lead);
                if (lead[5] && $urandom_range(1, 0) == 1) begin
                    stream.push_back(cont_byte());
                end
                if ($urandom_range(1, 0) == 1) begin
                    cut = 1'b1;
                end else begin
                    stream.push_back(non_cont_byte());
                end
            end else begin
                stream.push_back(8'($urandom_range(255, 1)));
            end
        end
        stream.push_back(8'h00);
    endtask

    task automatic send_byte(input logic [7:0] b, input int idx);
        if (!calm && (idx % 192) < 128 && $urandom_range(4, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        book.note_byte(b);
        @(negedge i_clk);
    endtask

    // hold result-side ready low in random bursts, with quiet stretches
    always @(negedge i_clk) begin
        rx_cycle++;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!calm && (rx_cycle % 256) < 160 && $urandom_range(5, 0) == 0) begin
            stall_left = $urandom_range(9, 0);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            book.check_verdict(o_valid_res, o_error_kind);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int calm_from;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_text_byte = 8'h00;

        stream = '{
            8'h00,
            8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
            8'hED, 8'h9F, 8'hBF, 8'hEF, 8'hBF, 8'hBF, 8'h00,
            8'hC0, 8'h80, 8'h00,
            8'hE0, 8'h9F, 8'hBF, 8'h00,
            8'hED, 8'hA0, 8'h80, 8'h00,
            8'hF0, 8'h00,
            8'hE0, 8'h80, 8'h7F, 8'h00,
            8'hC2, 8'h00,
            8'h80, 8'hFF, 8'h00
        };
        while (stream.size() < TARGET_BYTES) begin
            compose_string();
        end
        calm_from = stream.size() - CALM_TAIL;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < stream.size(); idx++) begin
            if (idx >= calm_from) begin
                calm = 1'b1;
            end
            send_byte(stream[idx], idx);
        end
        i_valid <= 1'b0;

        while (book.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### utf8_validator_three_byte_unit.f
design/u8v_pkg.sv
design/u8v_step.sv
design/utf8_validator_three_byte_unit.sv
bench/tb_top.sv
